// ----- hdl/debf_pkg.sv -----
package debf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_BITS   = 8;
    localparam int PIX_BITS    = 8;
    localparam int VALUE_BITS  = 9;
    localparam int IN_BITS     = 56;
    localparam int OUT_BITS    = 32;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] p3;
        logic [PIX_BITS-1:0] p2;
        logic [PIX_BITS-1:0] p1;
        logic [PIX_BITS-1:0] p0;
    } taps_t;

    typedef struct packed {
        taps_t taps;
        logic  steep;
    } row_t;

endpackage

// ----- hdl/debf_ram.sv -----
module debf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/debf_index.sv -----
module debf_index (
    input  debf_pkg::taps_t                   taps,
    output logic                              steep,
    output logic [debf_pkg::ADDR_BITS-1:0]    addr
);
    import debf_pkg::*;

    logic signed [PIX_BITS:0]   d01;
    logic signed [PIX_BITS:0]   d23;
    logic signed [PIX_BITS:0]   d21;
    logic signed [PIX_BITS:0]   d03;
    logic signed [PIX_BITS+3:0] value;
    logic signed [PIX_BITS+3:0] shifted;

    always_comb begin
        d01 = $signed({1'b0, taps.p0}) - $signed({1'b0, taps.p1});
        d23 = $signed({1'b0, taps.p2}) - $signed({1'b0, taps.p3});
        d21 = $signed({1'b0, taps.p2}) - $signed({1'b0, taps.p1});
        d03 = $signed({1'b0, taps.p0}) - $signed({1'b0, taps.p3});
        steep = (d01 > 9'sd1) || (d01 < -9'sd1) || (d23 > 9'sd1) || (d23 < -9'sd1);
        value = (PIX_BITS+4)'(d21) * 12'sd3 + (steep ? (PIX_BITS+4)'(d03) : 12'sd0)
                + 12'sd4;
        shifted = value >>> 3;
        // index plus bias, wraps to the table depth
        addr = shifted[ADDR_BITS-1:0] + ADDR_BITS'(127);
    end

endmodule

// ----- hdl/debf_apply.sv -----
module debf_apply #(
    parameter int DELTA_BITS = 9
) (
    input  debf_pkg::row_t                 row,
    input  logic signed [DELTA_BITS-1:0]   delta,
    output debf_pkg::taps_t                result
);
    import debf_pkg::*;

    localparam int SumBits = DELTA_BITS + 2;

    function automatic logic [PIX_BITS-1:0] sat_pixel(input logic signed [SumBits-1:0] v);
        logic [PIX_BITS-1:0] r;
        if (v < $signed(SumBits'(0))) begin
            r = '0;
        end else if (v > $signed(SumBits'(255))) begin
            r = '1;
        end else begin
            r = v[PIX_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [SumBits-1:0] delta_ext;
    logic signed [SumBits-1:0] half_ext;

    always_comb begin
        delta_ext = SumBits'(delta);
        half_ext  = delta_ext >>> 1;
        result.p1 = sat_pixel($signed(SumBits'({1'b0, row.taps.p1})) + delta_ext);
        result.p2 = sat_pixel($signed(SumBits'({1'b0, row.taps.p2})) - delta_ext);
        if (row.steep) begin
            result.p0 = row.taps.p0;
            result.p3 = row.taps.p3;
        end else begin
            result.p0 = sat_pixel($signed(SumBits'({1'b0, row.taps.p0})) + half_ext);
            result.p3 = sat_pixel($signed(SumBits'({1'b0, row.taps.p3})) - half_ext);
        end
    end

endmodule

// ----- hdl/deblock_edge_filter_row_core.sv -----
// channel   | direction | tdata (low bit up)                            | tuser
// s_axis    | in        | tap_zero tap_one tap_two tap_three            | opcode
//           |           | table_address table_value, zero fill to 56    |
// m_axis    | out       | out_zero out_one out_two out_three            | steep_row
// one transaction per cycle on each side unless the output stalls
// table lookup in a registered ram, then the output register, set the pipeline depth
// load transactions write the table on acceptance and give no result
// reset clears the valid flags only; table contents are undefined until loaded
// a stalled output holds its result and back-pressure reaches s_axis_tready
module deblock_edge_filter_row_core #(
    parameter int DELTA_BITS = 9
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [debf_pkg::IN_BITS-1:0]    s_axis_tdata,  // tap_zero tap_one tap_two tap_three table_address table_value
    input  logic                            s_axis_tuser,  // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [debf_pkg::OUT_BITS-1:0]   m_axis_tdata,  // out_zero out_one out_two out_three
    output logic                            m_axis_tuser   // steep_row
);
    import debf_pkg::*;

    opcode_t                       opcode;
    taps_t                         in_taps;
    row_t                          in_row;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic                          s_fire;
    logic                          out_free;
    logic                          tab_we;
    logic                          tab_re;
    logic signed [DELTA_BITS-1:0]  wr_value;
    logic signed [DELTA_BITS-1:0]  delta;
    taps_t                         filt_taps;

    logic                          s1_valid_reg;
    row_t                          s1_row_reg;
    logic                          m_valid_reg;
    taps_t                         m_taps_reg;
    logic                          m_steep_reg;

    assign opcode    = opcode_t'(s_axis_tuser);
    assign in_taps.p0 = s_axis_tdata[7:0];
    assign in_taps.p1 = s_axis_tdata[15:8];
    assign in_taps.p2 = s_axis_tdata[23:16];
    assign in_taps.p3 = s_axis_tdata[31:24];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign tab_we        = s_fire && (opcode == OP_LOAD);
    assign tab_re        = s_fire && (opcode == OP_FILTER);
    assign wr_value      = DELTA_BITS'($signed(s_axis_tdata[40 +: VALUE_BITS]));

    debf_index u_index (
        .taps  (in_taps),
        .steep (in_row.steep),
        .addr  (rd_addr)
    );

    assign in_row.taps = in_taps;

    debf_ram #(
        .WIDTH (DELTA_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tab_we),
        .wr_addr (s_axis_tdata[32 +: ADDR_BITS]),
        .wr_data (wr_value),
        .rd_en   (tab_re),
        .rd_addr (rd_addr),
        .rd_data (delta)
    );

    debf_apply #(
        .DELTA_BITS (DELTA_BITS)
    ) u_apply (
        .row    (s1_row_reg),
        .delta  (delta),
        .result (filt_taps)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                s1_valid_reg <= tab_re;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tab_re) begin
            s1_row_reg <= in_row;
        end
        if (out_free && s1_valid_reg) begin
            m_taps_reg  <= filt_taps;
            m_steep_reg <= s1_row_reg.steep;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_taps_reg.p3, m_taps_reg.p2, m_taps_reg.p1, m_taps_reg.p0};
    assign m_axis_tuser  = m_steep_reg;

endmodule

// ----- hdl/debf_checker.sv -----
module debf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [debf_pkg::OUT_BITS-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import debf_pkg::*;

    logic s_fire_filter;

    assign s_fire_filter = s_axis_tvalid && s_axis_tready
                           && (opcode_t'(s_axis_tuser) == OP_FILTER);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // empty output register never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a new result traces back through the table stage to an accepted filter transaction
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, 2) && $rose(m_axis_tvalid) |-> $past(s_fire_filter, 2))
        else $error("result without filter transaction");

endmodule

bind deblock_edge_filter_row_core debf_checker u_debf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
